@@ rtl/core/dual_reed_flow_counter_assert.svh @@
// assertion macros for the dual reed flow counter
// users need clk and rst_n in scope
`ifndef DUAL_REED_FLOW_COUNTER_ASSERT_SVH
`define DUAL_REED_FLOW_COUNTER_ASSERT_SVH

// property that holds at every clock edge out of reset
`define DRFC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define DRFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/drfc_pkg.sv @@
// shared types and constants of the dual reed flow counter
// no dependencies
package drfc_pkg;

  localparam int LOW_W      = 7;
  localparam int COUNT_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [LOW_W-1:0]   low_cnt_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BYTE_W-1:0]  byte_cnt_t;
  typedef logic [1:0]         switch_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam low_cnt_t  MAX_WINDOW        = 7'd127;
  localparam low_cnt_t  LOW_THRESHOLD_RST = 7'd95;
  localparam count_t    BASE_VOLUME_RST   = 32'd1578;
  localparam byte_cnt_t SAVE_INTERVAL_RST = 8'd20;

  localparam switch_t SW_NONE   = 2'd0;
  localparam switch_t SW_FIRST  = 2'd1;
  localparam switch_t SW_SECOND = 2'd2;

  localparam cfg_idx_t CFG_LOW_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_BASE_VOLUME   = 2'd1;
  localparam cfg_idx_t CFG_SAVE_INTERVAL = 2'd2;

  typedef struct packed {
    logic func;
    logic pin_low;
    logic window_end;
  } sample_t;

  typedef struct packed {
    logic      decided;
    logic      pulse_accepted;
    count_t    flow_count;
    byte_cnt_t fault_count;
    logic      fault_strobe;
    logic      save_strobe;
    count_t    save_value;
  } result_t;

endpackage

@@ rtl/core/drfc_if.sv @@
// input and result channel interfaces of the dual reed flow counter
// depends on drfc_pkg
interface drfc_in_if;
  logic valid;
  logic ready;
  logic func;
  logic pin_low;
  logic window_end;

  modport source (output valid, output func, output pin_low, output window_end, input ready);
  modport sink (input valid, input func, input pin_low, input window_end, output ready);
endinterface

interface drfc_out_if;
  logic                valid;
  logic                ready;
  logic                decided;
  logic                pulse_accepted;
  drfc_pkg::count_t    flow_count;
  drfc_pkg::byte_cnt_t fault_count;
  logic                fault_strobe;
  logic                save_strobe;
  drfc_pkg::count_t    save_value;

  modport source (output valid, output decided, output pulse_accepted, output flow_count,
                  output fault_count, output fault_strobe, output save_strobe,
                  output save_value, input ready);
  modport sink (input valid, input decided, input pulse_accepted, input flow_count,
                input fault_count, input fault_strobe, input save_strobe,
                input save_value, output ready);
endinterface

@@ rtl/core/drfc_tally.sv @@
// window counter, pulse qualification and flow/fault/save state
// depends on drfc_pkg and dual_reed_flow_counter_assert.svh
`include "dual_reed_flow_counter_assert.svh"

module drfc_tally (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  drfc_pkg::sample_t   smp,
  input  drfc_pkg::low_cnt_t  low_threshold,
  input  drfc_pkg::count_t    base_volume,
  input  drfc_pkg::byte_cnt_t save_interval,
  output drfc_pkg::result_t   res
);

  drfc_pkg::low_cnt_t  low_samples_r, low_samples_nxt, low_cnt;
  drfc_pkg::switch_t   last_switch_r, last_switch_nxt, sw;
  drfc_pkg::count_t    pulse_total_r, pulse_total_nxt;
  drfc_pkg::byte_cnt_t since_save_r, since_save_nxt, since_inc;
  drfc_pkg::byte_cnt_t error_total_r, error_total_nxt;
  logic                accepted, fault, save;

  always_comb begin
    sw              = smp.func ? drfc_pkg::SW_SECOND : drfc_pkg::SW_FIRST;
    low_cnt         = low_samples_r;
    low_samples_nxt = low_samples_r;
    last_switch_nxt = last_switch_r;
    pulse_total_nxt = pulse_total_r;
    since_save_nxt  = since_save_r;
    error_total_nxt = error_total_r;
    since_inc       = since_save_r + 1'b1;
    accepted        = 1'b0;
    fault           = 1'b0;
    save            = 1'b0;
    if (smp.pin_low && (low_samples_r < drfc_pkg::MAX_WINDOW)) begin
      low_cnt = low_samples_r + 1'b1;
    end
    low_samples_nxt = low_cnt;
    if (smp.window_end) begin
      low_samples_nxt = '0;
      if (low_cnt >= low_threshold) begin
        if (last_switch_r == sw) begin
          error_total_nxt = error_total_r + 1'b1;
          fault           = 1'b1;
        end else begin
          last_switch_nxt = sw;
          pulse_total_nxt = pulse_total_r + 1'b1;
          accepted        = 1'b1;
          if (since_inc >= save_interval) begin
            since_save_nxt = '0;
            save           = 1'b1;
          end else begin
            since_save_nxt = since_inc;
          end
        end
      end
    end
  end

  always_comb begin
    res.decided        = smp.window_end;
    res.pulse_accepted = accepted;
    res.flow_count     = pulse_total_nxt;
    res.fault_count    = error_total_nxt;
    res.fault_strobe   = fault;
    res.save_strobe    = save;
    res.save_value     = base_volume + (pulse_total_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_samples_r <= '0;
      last_switch_r <= drfc_pkg::SW_NONE;
      pulse_total_r <= '0;
      since_save_r  <= '0;
      error_total_r <= '0;
    end else if (fire) begin
      low_samples_r <= low_samples_nxt;
      last_switch_r <= last_switch_nxt;
      pulse_total_r <= pulse_total_nxt;
      since_save_r  <= since_save_nxt;
      error_total_r <= error_total_nxt;
    end
  end

  `DRFC_ASSERT_NEXT(a_idle_holds, !fire, $stable(pulse_total_r) && $stable(error_total_r), "counts moved without a word")
  `DRFC_ASSERT_NEXT(a_window_restart, fire && smp.window_end, low_samples_r == '0, "window counter not restarted")
  `DRFC_ASSERT_NEXT(a_pulse_switch, fire && res.pulse_accepted, last_switch_r != drfc_pkg::SW_NONE, "pulse left no switch")

endmodule

@@ rtl/core/dual_reed_flow_counter.sv @@
// dual reed switch flow counter, one result word per sample word
// an accepted word passes the input register, then the result register, before its result is valid
// throughput: one word per cycle while the receiver takes results, set by the single-pass update of the counters
// the result register frees the input side while a result waits to be taken
// reset: synchronous, active low; clears all counters and loads register defaults
// depends on drfc_pkg, drfc_if, drfc_tally and dual_reed_flow_counter_assert.svh
`include "dual_reed_flow_counter_assert.svh"

module dual_reed_flow_counter (
  input  logic               clk,
  input  logic               rst_n,
  drfc_in_if.sink            in_ch,
  drfc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  drfc_pkg::cfg_idx_t cfg_index,
  input  logic [drfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  drfc_pkg::low_cnt_t  low_threshold_r;
  drfc_pkg::count_t    base_volume_r;
  drfc_pkg::byte_cnt_t save_interval_r;

  logic              s1_valid_r;
  drfc_pkg::sample_t s1_smp_r;
  logic              out_valid_r;
  drfc_pkg::result_t out_r;
  drfc_pkg::result_t res;
  logic              in_accept, out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_threshold_r <= drfc_pkg::LOW_THRESHOLD_RST;
      base_volume_r   <= drfc_pkg::BASE_VOLUME_RST;
      save_interval_r <= drfc_pkg::SAVE_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drfc_pkg::CFG_LOW_THRESHOLD: low_threshold_r <= cfg_wdata[drfc_pkg::LOW_W-1:0];
        drfc_pkg::CFG_BASE_VOLUME:   base_volume_r   <= cfg_wdata[drfc_pkg::COUNT_W-1:0];
        drfc_pkg::CFG_SAVE_INTERVAL: save_interval_r <= cfg_wdata[drfc_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_smp_r.func       <= in_ch.func;
      s1_smp_r.pin_low    <= in_ch.pin_low;
      s1_smp_r.window_end <= in_ch.window_end;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  drfc_tally u_tally (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (out_load),
    .smp           (s1_smp_r),
    .low_threshold (low_threshold_r),
    .base_volume   (base_volume_r),
    .save_interval (save_interval_r),
    .res           (res)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.decided        = out_r.decided;
  assign out_ch.pulse_accepted = out_r.pulse_accepted;
  assign out_ch.flow_count     = out_r.flow_count;
  assign out_ch.fault_count    = out_r.fault_count;
  assign out_ch.fault_strobe   = out_r.fault_strobe;
  assign out_ch.save_strobe    = out_r.save_strobe;
  assign out_ch.save_value     = out_r.save_value;

  `DRFC_ASSERT_NEXT(a_in_captured, in_accept, s1_valid_r, "accepted word not held")
  `DRFC_ASSERT_NEXT(a_s1_kept, s1_valid_r && !out_load, s1_valid_r, "pending word dropped")
  `DRFC_ASSERT_NEXT(a_out_loaded, out_load, out_valid_r, "result not presented")

endmodule

@@ bench/dual_reed_flow_counter_tb.sv @@
`timescale 1ns / 100ps
// self-checking bench for dual_reed_flow_counter: random sample words, random stalls,
// register phases, a flow meter predictor compared word by word with the result channel
// depends on drfc_pkg, drfc_if and the dual_reed_flow_counter rtl
module dual_reed_flow_counter_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 34;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 250;
  localparam int CALM_FROM   = 800;
  localparam int CALM_TO     = 1000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  drfc_pkg::cfg_idx_t cfg_index;
  logic [drfc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  drfc_in_if  in_bus ();
  drfc_out_if out_bus ();

  dual_reed_flow_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus.sink),
    .out_ch    (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state and register copies
  drfc_pkg::low_cnt_t  cfg_threshold;
  drfc_pkg::count_t    cfg_base;
  drfc_pkg::byte_cnt_t cfg_interval;
  drfc_pkg::switch_t   last_switch;
  drfc_pkg::count_t    pulse_total;
  drfc_pkg::byte_cnt_t since_save;
  drfc_pkg::byte_cnt_t fault_total;
  drfc_pkg::low_cnt_t  low_samples;

  drfc_pkg::sample_t sample_queue[$];
  drfc_pkg::result_t expected_readings[$];
  int      queued;
  int      words_in;
  int      mismatches;
  int      cycles;
  int      hold_left;
  bit      hold_done;
  logic    calm;

  assign calm = (words_in >= CALM_FROM) && (words_in < CALM_TO);

  always #10 clk = ~clk;

  function automatic drfc_pkg::result_t meter_step(drfc_pkg::sample_t s);
    drfc_pkg::switch_t sw;
    drfc_pkg::result_t r;
    logic qualified;
    sw = s.func ? drfc_pkg::SW_SECOND : drfc_pkg::SW_FIRST;
    r = '0;
    if (s.pin_low && low_samples < drfc_pkg::MAX_WINDOW) low_samples = low_samples + 1'b1;
    if (s.window_end) begin
      qualified = low_samples >= cfg_threshold;
      low_samples = '0;
      if (qualified) begin
        if (last_switch == sw) begin
          fault_total = fault_total + 1'b1;
          r.fault_strobe = 1'b1;
        end else begin
          last_switch = sw;
          pulse_total = pulse_total + 1'b1;
          r.pulse_accepted = 1'b1;
          since_save = since_save + 1'b1;
          if (since_save >= cfg_interval) begin
            since_save = '0;
            r.save_strobe = 1'b1;
          end
        end
      end
    end
    r.decided     = s.window_end;
    r.flow_count  = pulse_total;
    r.fault_count = fault_total;
    r.save_value  = cfg_base + (pulse_total >> 1);
    return r;
  endfunction

  // prints are capped so a broken block cannot flood the log
  task automatic report(string msg);
    if (mismatches < 50) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic write_register(drfc_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      drfc_pkg::CFG_LOW_THRESHOLD: cfg_threshold = val[drfc_pkg::LOW_W-1:0];
      drfc_pkg::CFG_BASE_VOLUME:   cfg_base = val;
      drfc_pkg::CFG_SAVE_INTERVAL: cfg_interval = val[drfc_pkg::BYTE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int threshold, logic [31:0] base, int interval);
    write_register(drfc_pkg::CFG_LOW_THRESHOLD, 32'(threshold));
    write_register(drfc_pkg::CFG_BASE_VOLUME, base);
    write_register(drfc_pkg::CFG_SAVE_INTERVAL, 32'(interval));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sample_queue.size() != 0 || expected_readings.size() != 0);
  endtask

  task automatic add_sample(logic f, logic low, logic last);
    drfc_pkg::sample_t s;
    s.func       = f;
    s.pin_low    = low;
    s.window_end = last;
    sample_queue.push_back(s);
    queued++;
  endtask

  task automatic add_window(logic f, int len, int low_pct, bit mix);
    for (int i = 0; i < len; i++) begin
      add_sample((i == len - 1 || !mix) ? f : 1'($urandom_range(1)),
                 $urandom_range(99) < low_pct, i == len - 1);
    end
  endtask

  task automatic add_noise(int n, int end_pct);
    for (int i = 0; i < n; i++)
      add_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(99) < end_pct);
  endtask

  // well-formed windows, mostly alternating switches, with some noise bursts
  task automatic add_flow(int n, int max_len);
    int start;
    logic f;
    start = queued;
    f = 1'($urandom_range(1));
    while (queued - start < n) begin
      if ($urandom_range(9) == 0) begin
        add_noise($urandom_range(1, 5), 20);
      end else begin
        if ($urandom_range(99) < 80) f = ~f;
        add_window(f, $urandom_range(1, max_len), $urandom_range(40, 100),
                   1'($urandom_range(1)));
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin : drive
    drfc_pkg::sample_t s;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      words_in <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        s = sample_queue.pop_front();
        expected_readings.push_back(meter_step(s));
        words_in <= words_in + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_bus.valid      <= 1'b1;
          in_bus.func       <= sample_queue[0].func;
          in_bus.pin_low    <= sample_queue[0].pin_low;
          in_bus.window_end <= sample_queue[0].window_end;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    drfc_pkg::result_t got;
    drfc_pkg::result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.decided        = out_bus.decided;
        got.pulse_accepted = out_bus.pulse_accepted;
        got.flow_count     = out_bus.flow_count;
        got.fault_count    = out_bus.fault_count;
        got.fault_strobe   = out_bus.fault_strobe;
        got.save_strobe    = out_bus.save_strobe;
        got.save_value     = out_bus.save_value;
        if (expected_readings.size() == 0) begin
          report("result word with none expected");
        end else begin
          want = expected_readings.pop_front();
          check_field("decided", 32'(got.decided), 32'(want.decided));
          check_field("pulse_accepted", 32'(got.pulse_accepted), 32'(want.pulse_accepted));
          check_field("flow_count", got.flow_count, want.flow_count);
          check_field("fault_count", 32'(got.fault_count), 32'(want.fault_count));
          check_field("fault_strobe", 32'(got.fault_strobe), 32'(want.fault_strobe));
          check_field("save_strobe", 32'(got.save_strobe), 32'(want.save_strobe));
          check_field("save_value", got.save_value, want.save_value);
        end
      end
      out_bus.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** dual_reed_flow_counter: FAILED **");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = drfc_pkg::CFG_LOW_THRESHOLD;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.func = 1'b0;
    in_bus.pin_low = 1'b0;
    in_bus.window_end = 1'b0;
    out_bus.ready = 1'b0;
    cycles = 0;
    queued = 0;
    mismatches = 0;
    words_in = 0;
    hold_left = 0;
    cfg_threshold = drfc_pkg::LOW_THRESHOLD_RST;
    cfg_base = drfc_pkg::BASE_VOLUME_RST;
    cfg_interval = drfc_pkg::SAVE_INTERVAL_RST;
    last_switch = drfc_pkg::SW_NONE;
    pulse_total = '0;
    since_save = '0;
    fault_total = '0;
    low_samples = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first pulse, repeat fault, mixed window, short windows, save value wrap
    set_config(2, 32'hFFFF_FFFF, 1);
    add_sample(1'b0, 1'b1, 1'b0);
    add_sample(1'b0, 1'b1, 1'b1);
    add_sample(1'b0, 1'b1, 1'b0);
    add_sample(1'b0, 1'b1, 1'b0);
    add_sample(1'b0, 1'b0, 1'b1);
    add_sample(1'b0, 1'b1, 1'b0);
    add_sample(1'b1, 1'b1, 1'b1);
    add_sample(1'b1, 1'b1, 1'b1);
    add_sample(1'b1, 1'b0, 1'b1);
    add_sample(1'b0, 1'b0, 1'b0);
    add_sample(1'b1, 1'b1, 1'b0);
    add_sample(1'b0, 1'b1, 1'b1);
    wait_drained();

    // zero threshold and zero save interval
    set_config(0, 32'd0, 0);
    add_sample(1'b0, 1'b0, 1'b1);
    add_sample(1'b1, 1'b0, 1'b1);
    add_sample(1'b0, 1'b0, 1'b1);
    add_sample(1'b1, 1'b1, 1'b0);
    add_sample(1'b1, 1'b1, 1'b1);
    add_sample(1'b0, 1'b0, 1'b1);
    add_sample(1'b1, 1'b0, 1'b1);
    wait_drained();

    // interval lowered below the pulses already counted since the last save
    write_register(drfc_pkg::CFG_SAVE_INTERVAL, 32'd200);
    @(negedge clk);
    add_sample(1'b0, 1'b0, 1'b1);
    add_sample(1'b1, 1'b0, 1'b1);
    add_sample(1'b0, 1'b0, 1'b1);
    wait_drained();
    write_register(drfc_pkg::CFG_SAVE_INTERVAL, 32'd1);
    @(negedge clk);
    add_sample(1'b1, 1'b0, 1'b1);
    wait_drained();

    // short windows, low thresholds
    set_config($urandom_range(1, 10), $urandom(), $urandom_range(1, 8));
    add_flow(250, 15);
    wait_drained();

    // same switch over and over so the fault count wraps
    set_config(0, 32'd0, 255);
    for (int i = 0; i < 300; i++) add_sample(1'b0, 1'($urandom_range(1)), 1'b1);
    wait_drained();

    // noise with frequent window ends
    set_config(0, $urandom(), $urandom_range(1, 255));
    add_noise(150, 50);
    wait_drained();

    // long windows that saturate the low sample counter at the top threshold
    set_config(127, 32'hFFFF_FFFF, 2);
    add_window(1'b1, $urandom_range(130, 150), 100, 1'b1);
    add_window(1'b0, $urandom_range(130, 150), 100, 1'b1);
    add_window(1'b1, $urandom_range(126, 140), 97, 1'b1);
    wait_drained();

    // everything random, defaults among the settings
    set_config(95, 32'd1578, 20);
    add_flow(100, 130);
    wait_drained();
    set_config($urandom_range(0, 20), $urandom(), $urandom_range(1, 255));
    add_flow(150, 30);
    add_noise(100, 15);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("** dual_reed_flow_counter: PASSED **");
    end else begin
      $display("** dual_reed_flow_counter: FAILED **");
    end
    $finish;
  end

endmodule
